// ===== design/mrsa_pkg.sv =====
// Shared types and constants of the management-route slot allocator.
`timescale 1ns / 1ps

package mrsa_pkg;

    // Result codes reported in the status field.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_PARAM_ERR = 2'd1,
        STAT_NO_SLOT   = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP_F,
        S_SWEEP_N,
        S_FIND,
        S_EVICT,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clr_idx;
        logic    sweep_en;
        logic    sweep_force;
        logic    alloc_en;
        logic    evict_en;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func_free;
        logic port_err;
        logic have_free;
        logic idx_last;
        logic evict_hit;
    } sts_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam int          FUNC_CREATE   = 0;
    localparam int          FUNC_FREE     = 1;

endpackage

// ===== design/mrsa_ctrl.sv =====
// Controller state machine of the management-route slot allocator.
`timescale 1ns / 1ps

module mrsa_ctrl
    import mrsa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.func_free) begin
                    state_next = S_SWEEP_F;
                end else if (sts.port_err) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_PARAM_ERR;
                    state_next     = S_OUT;
                end else if (sts.have_free) begin
                    cmd.alloc_en = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_SWEEP_N;
                end
            end
            S_SWEEP_F: begin
                cmd.sweep_en    = 1'b1;
                cmd.sweep_force = 1'b1;
                if (sts.idx_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_OK;
                    state_next     = S_OUT;
                end
            end
            S_SWEEP_N: begin
                cmd.sweep_en = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                cmd.clr_idx = 1'b1;
                if (sts.have_free) begin
                    cmd.alloc_en = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT: begin
                cmd.evict_en = 1'b1;
                if (sts.evict_hit) begin
                    state_next = S_OUT;
                end else if (sts.idx_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_NO_SLOT;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/mrsa_datapath.sv =====
// Datapath of the management-route slot allocator: slot table, counters, result register.
`timescale 1ns / 1ps

module mrsa_datapath
    import mrsa_pkg::*;
#(
    parameter int SLOTS = 4,
    parameter int PORTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_func,
    input  logic [31:0] in_now,
    input  logic [3:0]  in_used,
    input  logic        in_force,
    input  logic [7:0]  in_ports,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [1:0]  out_status,
    output logic [1:0]  out_slot,
    output logic [3:0]  out_taken,
    output logic [31:0] out_sent,
    output logic [31:0] out_dropped
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Captured request.
    logic        func_reg;
    logic [31:0] now_reg;
    logic [3:0]  used_reg;
    logic        force_reg;
    logic [7:0]  ports_reg;

    // Slot table and counters.
    logic [SLOTS-1:0] taken_reg, taken_next;
    logic [31:0]      stamp_reg [SLOTS];
    logic [31:0]      sent_reg, sent_next;
    logic [31:0]      drop_reg, drop_next;
    logic [31:0]      timeout_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [1:0]       res_slot_reg, res_slot_next;

    // Result register.
    logic [1:0]  out_status_reg;
    logic [1:0]  out_slot_reg;
    logic [3:0]  out_taken_reg;
    logic [31:0] out_sent_reg;
    logic [31:0] out_drop_reg;

    logic [SLOTS-1:0] used_ext;
    logic [3:0]       taken_view;
    logic [IDX_W-1:0] free_idx;
    logic             have_free;
    logic [31:0]      age;
    logic             age_hit;
    logic             idx_last;
    logic             stamp_we;
    logic [IDX_W-1:0] stamp_addr;

    // Slots above the fourth have no used bit and are not shown in the mask.
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_used
        if (gi < 4) begin : g_have
            assign used_ext[gi] = used_reg[gi];
        end else begin : g_none
            assign used_ext[gi] = 1'b0;
        end
    end

    for (genvar gj = 0; gj < 4; gj++) begin : g_view
        if (gj < SLOTS) begin : g_have
            assign taken_view[gj] = taken_reg[gj];
        end else begin : g_none
            assign taken_view[gj] = 1'b0;
        end
    end

    // Lowest free slot.
    always_comb begin
        free_idx  = '0;
        have_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!taken_reg[i]) begin
                free_idx  = IDX_W'(i);
                have_free = 1'b1;
            end
        end
    end

    assign age      = now_reg - stamp_reg[idx_reg];
    assign age_hit  = age > timeout_reg;
    assign idx_last = idx_reg == IDX_W'(SLOTS - 1);

    assign sts.func_free = func_reg == 1'(FUNC_FREE);
    assign sts.port_err  = (9'(ports_reg) >> PORTS) != 9'd0;
    assign sts.have_free = have_free;
    assign sts.idx_last  = idx_last;
    assign sts.evict_hit = age_hit;

    always_comb begin
        taken_next      = taken_reg;
        sent_next       = sent_reg;
        drop_next       = drop_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        stamp_we        = 1'b0;
        stamp_addr      = free_idx;

        if (cmd.load || cmd.clr_idx) begin
            idx_next = '0;
        end

        if (cmd.sweep_en) begin
            idx_next = idx_reg + IDX_W'(1);
            if (taken_reg[idx_reg]) begin
                if (used_ext[idx_reg]) begin
                    sent_next           = sent_reg + 32'd1;
                    taken_next[idx_reg] = 1'b0;
                end else if (cmd.sweep_force && force_reg) begin
                    drop_next           = drop_reg + 32'd1;
                    taken_next[idx_reg] = 1'b0;
                end
            end
        end

        if (cmd.alloc_en) begin
            taken_next[free_idx] = 1'b1;
            stamp_we             = 1'b1;
            stamp_addr           = free_idx;
            res_status_next      = STAT_OK;
            res_slot_next        = 2'(free_idx);
        end

        // Eviction releases the slot and takes it again at once.
        if (cmd.evict_en) begin
            idx_next = idx_reg + IDX_W'(1);
            if (age_hit) begin
                drop_next       = drop_reg + 32'd1;
                stamp_we        = 1'b1;
                stamp_addr      = idx_reg;
                res_status_next = STAT_OK;
                res_slot_next   = 2'(idx_reg);
            end
        end

        if (cmd.set_status) begin
            res_status_next = cmd.status;
            res_slot_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg   <= '0;
            sent_reg    <= '0;
            drop_reg    <= '0;
            idx_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            taken_reg <= taken_next;
            sent_reg  <= sent_next;
            drop_reg  <= drop_next;
            idx_reg   <= idx_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (stamp_we) begin
            stamp_reg[stamp_addr] <= now_reg;
        end
        if (cmd.load) begin
            func_reg  <= in_func;
            now_reg   <= in_now;
            used_reg  <= in_used;
            force_reg <= in_force;
            ports_reg <= in_ports;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_taken_reg  <= taken_view;
            out_sent_reg   <= sent_reg;
            out_drop_reg   <= drop_reg;
        end
    end

    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_taken   = out_taken_reg;
    assign out_sent    = out_sent_reg;
    assign out_dropped = out_drop_reg;

`ifndef ASSERT_OFF
    a_alloc_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_en |-> have_free)
        else $error("allocation issued with no free slot");

    a_evict_all_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict_en |-> !have_free)
        else $error("eviction scan while a slot is free");

    a_forced_sweep_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep_en && cmd.sweep_force && force_reg) |=> !taken_reg[$past(idx_reg)])
        else $error("forced sweep left a slot taken");

    a_sent_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> (sent_reg == $past(sent_reg) || sent_reg == $past(sent_reg) + 32'd1))
        else $error("sent counter moved by more than one");
`endif

endmodule

// ===== design/mgmt_route_slot_allocator_unit.sv =====
// Top level of the management-route slot allocator: stream ports, controller and datapath.
`timescale 1ns / 1ps
// A rejected or directly served create passes from the input transfer through decode to the
// result; a free sweep also sweeps every slot, and a create with no free slot sweeps, searches
// for a free slot and may then scan for an evictable slot; one slot is examined per cycle.
// One request is handled at a time; a new transfer is taken in the cycle after the result loads.
// Reset (aresetn low, synchronous) clears all taken flags, both counters and the output
// valid, and sets the timeout to 1000 ms; allocation timestamps are not cleared.

module mgmt_route_slot_allocator_unit
    import mrsa_pkg::*;
#(
    parameter int SLOTS = 4,
    parameter int PORTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], used_mask[35:32], force_req[36], port_mask[44:37], zero pad
    input  logic [47:0] s_tdata,
    // func[0]: 0 create route, 1 free sweep
    input  logic        s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], slot[3:2], taken_mask[7:4], sent_total[39:8], dropped_total[71:40]
    output logic [71:0] m_tdata,
    // Timeout register write port.
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    cmd_t        cmd;
    sts_t        sts;
    logic [1:0]  out_status;
    logic [1:0]  out_slot;
    logic [3:0]  out_taken;
    logic [31:0] out_sent;
    logic [31:0] out_dropped;

    // The controller walks each request through decode and, as needed, sweep, free-slot search and
    // eviction scan, and waits in its output state until the result register is free to load.
    mrsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the slot table, the counters, the timeout register and the
    // result register that decouples the two channels.
    mrsa_datapath #(
        .SLOTS (SLOTS),
        .PORTS (PORTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_func     (s_tuser),
        .in_now      (s_tdata[31:0]),
        .in_used     (s_tdata[35:32]),
        .in_force    (s_tdata[36]),
        .in_ports    (s_tdata[44:37]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (out_status),
        .out_slot    (out_slot),
        .out_taken   (out_taken),
        .out_sent    (out_sent),
        .out_dropped (out_dropped)
    );

    assign m_tdata = {out_dropped, out_sent, out_taken, out_slot, out_status};

endmodule
